>>> hw/rtl/lsos_pkg.sv
// Package for the lidar sector obstacle steering unit.
// Holds field widths, input kind codes, case codes, register indices and the fixed reset and speed constants.
// No dependencies.
package lsos_pkg;

  localparam int RangeW   = 16;
  localparam int PosW     = 12;
  localparam int WidthW   = 7;
  localparam int FactorW  = 6;
  localparam int LinearW  = 15;
  localparam int AngularW = 10;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_SPEED_UP  = 2'd1,
    KIND_SLOW_DOWN = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    CASE_CLEAR       = 4'd0,
    CASE_FRONT       = 4'd1,
    CASE_RIGHT_DIAG  = 4'd2,
    CASE_LEFT_DIAG   = 4'd3,
    CASE_FRONT_RIGHT = 4'd4,
    CASE_FRONT_LEFT  = 4'd5,
    CASE_ALL         = 4'd6,
    CASE_DIAGS       = 4'd7,
    CASE_UNKNOWN     = 4'd8
  } case_code_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_FRONT_START = 3'd1,
    REG_LEFT_START  = 3'd2,
    REG_RIGHT_START = 3'd3,
    REG_SECTOR_W    = 3'd4
  } reg_index_t;

  localparam logic [RangeW-1:0]  MinReset        = 16'd30000;
  localparam logic [RangeW-1:0]  ThresholdReset  = 16'd900;
  localparam logic [PosW-1:0]    FrontStartReset = 12'd355;
  localparam logic [PosW-1:0]    LeftStartReset  = 12'd499;
  localparam logic [PosW-1:0]    RightStartReset = 12'd211;
  localparam logic [WidthW-1:0]  SectorWReset    = 7'd10;

  // Speeds: mm/s per unit of speed factor, and the fixed turn rate.
  localparam logic signed [16:0] LinClear = 17'sd600;
  localparam logic signed [16:0] LinDiags = 17'sd500;
  localparam logic signed [AngularW-1:0] TurnRate = 10'sd500;
  localparam logic signed [16:0] LinMax = 17'sd16383;
  localparam logic signed [16:0] LinMin = -17'sd16384;

endpackage

>>> hw/rtl/lidar_sector_obstacle_steer_unit.sv
// Lidar sector obstacle steering unit: running sector minimums and steering table.
// Depends on lsos_pkg.
// A last-of-scan sample's result is loaded into the output register on acceptance.
// Throughput: 1 input transaction per cycle; the output register frees the
// input side whenever it is empty or being drained in the same cycle.
// Reset (rst, synchronous): registers to their defaults, minimums to 30 m,
// speed factor 1, held speeds 0, no result pending.
module lidar_sector_obstacle_steer_unit #(
  parameter int SAMPLES_PER_SCAN   = 720,
  parameter int SPEED_FACTOR_LIMIT = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lsos_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [lsos_pkg::CfgDataW-1:0]          cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             kind,
  input  logic [lsos_pkg::RangeW-1:0]            range_mm,
  input  logic                                   last_of_scan,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [3:0]                             case_code,
  output logic signed [lsos_pkg::LinearW-1:0]    linear_mm_s,
  output logic signed [lsos_pkg::AngularW-1:0]   angular_mrad_s
);

  localparam int RW = lsos_pkg::RangeW;
  localparam int PW = lsos_pkg::PosW;
  localparam int FW = lsos_pkg::FactorW;
  localparam int LW = lsos_pkg::LinearW;
  localparam int AW = lsos_pkg::AngularW;
  localparam logic signed [FW-1:0] FactorMax = FW'(SPEED_FACTOR_LIMIT);
  localparam logic signed [FW-1:0] FactorMin = -FW'(SPEED_FACTOR_LIMIT);
  localparam logic [PW:0] ScanLen = (PW+1)'(SAMPLES_PER_SCAN);

  // configuration registers
  logic [RW-1:0]                  threshold;
  logic [PW-1:0]                  front_start;
  logic [PW-1:0]                  left_start;
  logic [PW-1:0]                  right_start;
  logic [lsos_pkg::WidthW-1:0]    sector_width;

  // scan state
  logic [PW-1:0]                  pos;
  logic [RW-1:0]                  front_min, left_min, right_min;
  logic signed [FW-1:0]           spd_scale;
  logic signed [LW-1:0]           held_linear;
  logic signed [AW-1:0]           held_angular;

  logic                           in_fire;
  logic                           is_sample;
  logic                           result;
  logic [RW-1:0]                  front_cur, left_cur, right_cur;
  logic [PW:0]                    pos_inc;
  logic [PW-1:0]                  pos_next;
  logic                           f_blk, l_blk, r_blk, at_thr;
  lsos_pkg::case_code_t           code;
  logic signed [16:0]             lin_raw, lin_sat;
  logic signed [LW-1:0]           lin_next;
  logic signed [AW-1:0]           ang_next;
  logic signed [16:0]             sf_ext;

  function automatic logic in_sector(input logic [PW-1:0] p, input logic [PW-1:0] start,
                                     input logic [lsos_pkg::WidthW-1:0] width);
    logic [PW:0] stop;
    stop = {1'b0, start} + (PW+1)'(width);
    return (p >= start) && ({1'b0, p} < stop);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_sample = (kind == lsos_pkg::KIND_SAMPLE);
  assign result    = in_fire && is_sample && last_of_scan;

  // minimums including the current sample
  always_comb begin
    front_cur = front_min;
    left_cur  = left_min;
    right_cur = right_min;
    if (in_sector(pos, front_start, sector_width) && range_mm < front_min) begin
      front_cur = range_mm;
    end
    if (in_sector(pos, left_start, sector_width) && range_mm < left_min) begin
      left_cur = range_mm;
    end
    if (in_sector(pos, right_start, sector_width) && range_mm < right_min) begin
      right_cur = range_mm;
    end
  end

  always_comb begin
    pos_inc  = {1'b0, pos} + (PW+1)'(1);
    pos_next = (pos_inc >= ScanLen) ? '0 : pos_inc[PW-1:0];
  end

  // steering table
  always_comb begin
    f_blk  = front_cur < threshold;
    l_blk  = left_cur < threshold;
    r_blk  = right_cur < threshold;
    at_thr = (front_cur == threshold) || (left_cur == threshold) ||
             (right_cur == threshold);
    sf_ext = 17'(spd_scale);
    lin_raw = '0;
    ang_next = '0;
    case ({f_blk, l_blk, r_blk})
      3'b000: begin
        code    = lsos_pkg::CASE_CLEAR;
        lin_raw = sf_ext * lsos_pkg::LinClear;
      end
      3'b100: begin
        code     = lsos_pkg::CASE_FRONT;
        ang_next = lsos_pkg::TurnRate;
      end
      3'b001: begin
        code     = lsos_pkg::CASE_RIGHT_DIAG;
        ang_next = lsos_pkg::TurnRate;
      end
      3'b010: begin
        code     = lsos_pkg::CASE_LEFT_DIAG;
        ang_next = -lsos_pkg::TurnRate;
      end
      3'b101: begin
        code     = lsos_pkg::CASE_FRONT_RIGHT;
        ang_next = lsos_pkg::TurnRate;
      end
      3'b110: begin
        code     = lsos_pkg::CASE_FRONT_LEFT;
        ang_next = -lsos_pkg::TurnRate;
      end
      3'b111: begin
        code     = lsos_pkg::CASE_ALL;
        ang_next = lsos_pkg::TurnRate;
      end
      default: begin
        code    = lsos_pkg::CASE_DIAGS;
        lin_raw = sf_ext * lsos_pkg::LinDiags;
      end
    endcase
    if (lin_raw > lsos_pkg::LinMax) begin
      lin_sat = lsos_pkg::LinMax;
    end else if (lin_raw < lsos_pkg::LinMin) begin
      lin_sat = lsos_pkg::LinMin;
    end else begin
      lin_sat = lin_raw;
    end
    lin_next = lin_sat[LW-1:0];
    if (at_thr) begin
      code     = lsos_pkg::CASE_UNKNOWN;
      lin_next = held_linear;
      ang_next = held_angular;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= lsos_pkg::ThresholdReset;
      front_start  <= lsos_pkg::FrontStartReset;
      left_start   <= lsos_pkg::LeftStartReset;
      right_start  <= lsos_pkg::RightStartReset;
      sector_width <= lsos_pkg::SectorWReset;
      pos          <= '0;
      front_min    <= lsos_pkg::MinReset;
      left_min     <= lsos_pkg::MinReset;
      right_min    <= lsos_pkg::MinReset;
      spd_scale    <= FW'(1);
      held_linear  <= '0;
      held_angular <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsos_pkg::REG_THRESHOLD:   threshold    <= cfg_data;
          lsos_pkg::REG_FRONT_START: front_start  <= cfg_data[PW-1:0];
          lsos_pkg::REG_LEFT_START:  left_start   <= cfg_data[PW-1:0];
          lsos_pkg::REG_RIGHT_START: right_start  <= cfg_data[PW-1:0];
          lsos_pkg::REG_SECTOR_W:    sector_width <= cfg_data[lsos_pkg::WidthW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        case (kind)
          lsos_pkg::KIND_SPEED_UP: begin
            if (spd_scale < FactorMax) spd_scale <= spd_scale + FW'(1);
          end
          lsos_pkg::KIND_SLOW_DOWN: begin
            if (spd_scale > FactorMin) spd_scale <= spd_scale - FW'(1);
          end
          lsos_pkg::KIND_SAMPLE: begin
            if (last_of_scan) begin
              front_min <= lsos_pkg::MinReset;
              left_min  <= lsos_pkg::MinReset;
              right_min <= lsos_pkg::MinReset;
              pos       <= '0;
              held_linear  <= lin_next;
              held_angular <= ang_next;
            end else begin
              front_min <= front_cur;
              left_min  <= left_cur;
              right_min <= right_cur;
              pos       <= pos_next;
            end
          end
          default: ;
        endcase
      end

      if (result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded only when a scan closes
  always_ff @(posedge clk) begin
    if (result) begin
      case_code      <= code;
      linear_mm_s    <= lin_next;
      angular_mrad_s <= ang_next;
    end
  end

endmodule

>>> test/lidar_sector_obstacle_steer_unit_tb.sv
// Testbench for lidar_sector_obstacle_steer_unit: a shadow model of the sector minimums and
// steering table predicts every steering command. Directed scans come first, then random traffic.
// Depends on lsos_pkg and the unit's RTL.
module lidar_sector_obstacle_steer_unit_tb;

  localparam int ScanLen      = 720;
  localparam int FactorLimit  = 16;
  localparam int RandomItems  = 200;
  localparam int DrainCycles  = 4;

  typedef struct {
    lsos_pkg::case_code_t code;
    logic signed [14:0]   lin;
    logic signed [9:0]    ang;
  } steer_cmd_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  cfg_valid;
  logic                                  cfg_ready;
  logic [lsos_pkg::CfgIdxW-1:0]          cfg_index;
  logic [lsos_pkg::CfgDataW-1:0]         cfg_data;
  logic                                  in_valid;
  logic                                  in_ready;
  logic [1:0]                            kind;
  logic [lsos_pkg::RangeW-1:0]           range_mm;
  logic                                  last_of_scan;
  logic                                  out_valid;
  logic                                  out_ready;
  logic [3:0]                            case_code;
  logic signed [lsos_pkg::LinearW-1:0]   linear_mm_s;
  logic signed [lsos_pkg::AngularW-1:0]  angular_mrad_s;

  // Shadow configuration and state
  logic [15:0]        shadow_thr;
  logic [11:0]        shadow_front, shadow_left, shadow_right;
  logic [6:0]         shadow_width;
  int unsigned        scan_pos;
  logic [15:0]        front_low, left_low, right_low;
  int                 spd_scale;
  logic signed [14:0] held_lin;
  logic signed [9:0]  held_ang;
  steer_cmd_t         steer_expect_q[$];

  int mismatch_count = 0;
  int tx_gap_max = 0;
  int rx_gap_max = 0;
  int hold_off_cycles = 0;
  int random_items = 0;

  lidar_sector_obstacle_steer_unit #(
    .SAMPLES_PER_SCAN   (ScanLen),
    .SPEED_FACTOR_LIMIT (FactorLimit)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .range_mm       (range_mm),
    .last_of_scan   (last_of_scan),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .case_code      (case_code),
    .linear_mm_s    (linear_mm_s),
    .angular_mrad_s (angular_mrad_s)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic bit in_window(int unsigned p, logic [11:0] start);
    return (int'(p) >= int'(start)) && (int'(p) < int'(start) + int'(shadow_width));
  endfunction

  function automatic logic signed [14:0] clamp_linear(int v);
    if (v > 16383) return 15'sd16383;
    if (v < -16384) return -15'sd16384;
    return v[14:0];
  endfunction

  task automatic predict_steer(lsos_pkg::kind_t k, logic [15:0] r, logic is_last);
    steer_cmd_t res;
    logic f, l, rt;
    case (k)
      lsos_pkg::KIND_SPEED_UP: if (spd_scale < FactorLimit) spd_scale++;
      lsos_pkg::KIND_SLOW_DOWN: if (spd_scale > -FactorLimit) spd_scale--;
      lsos_pkg::KIND_SAMPLE: begin
        if (in_window(scan_pos, shadow_front) && r < front_low) front_low = r;
        if (in_window(scan_pos, shadow_left) && r < left_low) left_low = r;
        if (in_window(scan_pos, shadow_right) && r < right_low) right_low = r;
        if (!is_last) begin
          scan_pos++;
          if (scan_pos >= ScanLen) scan_pos = 0;
        end else begin
          if (front_low == shadow_thr || left_low == shadow_thr || right_low == shadow_thr) begin
            res.code = lsos_pkg::CASE_UNKNOWN;
          end else begin
            f = front_low < shadow_thr;
            l = left_low < shadow_thr;
            rt = right_low < shadow_thr;
            case ({f, l, rt})
              3'b000: begin
                res.code = lsos_pkg::CASE_CLEAR;
                held_lin = clamp_linear(600 * spd_scale);
                held_ang = '0;
              end
              3'b100: begin
                res.code = lsos_pkg::CASE_FRONT; held_lin = '0; held_ang = 10'sd500;
              end
              3'b001: begin
                res.code = lsos_pkg::CASE_RIGHT_DIAG; held_lin = '0; held_ang = 10'sd500;
              end
              3'b010: begin
                res.code = lsos_pkg::CASE_LEFT_DIAG; held_lin = '0; held_ang = -10'sd500;
              end
              3'b101: begin
                res.code = lsos_pkg::CASE_FRONT_RIGHT; held_lin = '0; held_ang = 10'sd500;
              end
              3'b110: begin
                res.code = lsos_pkg::CASE_FRONT_LEFT; held_lin = '0; held_ang = -10'sd500;
              end
              3'b111: begin
                res.code = lsos_pkg::CASE_ALL; held_lin = '0; held_ang = 10'sd500;
              end
              default: begin
                res.code = lsos_pkg::CASE_DIAGS;
                held_lin = clamp_linear(500 * spd_scale);
                held_ang = '0;
              end
            endcase
          end
          res.lin = held_lin;
          res.ang = held_ang;
          steer_expect_q.push_back(res);
          front_low = 16'd30000;
          left_low = 16'd30000;
          right_low = 16'd30000;
          scan_pos = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Shadow model update and result check, all on sampled values at the rising edge
  always @(posedge clk) begin : scoreboard_side
    steer_cmd_t want;
    if (rst) begin
      shadow_thr = 16'd900;
      shadow_front = 12'd355;
      shadow_left = 12'd499;
      shadow_right = 12'd211;
      shadow_width = 7'd10;
      scan_pos = 0;
      front_low = 16'd30000;
      left_low = 16'd30000;
      right_low = 16'd30000;
      spd_scale = 1;
      held_lin = '0;
      held_ang = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (lsos_pkg::reg_index_t'(cfg_index))
          lsos_pkg::REG_THRESHOLD:   shadow_thr = cfg_data;
          lsos_pkg::REG_FRONT_START: shadow_front = cfg_data[11:0];
          lsos_pkg::REG_LEFT_START:  shadow_left = cfg_data[11:0];
          lsos_pkg::REG_RIGHT_START: shadow_right = cfg_data[11:0];
          lsos_pkg::REG_SECTOR_W:    shadow_width = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_steer(lsos_pkg::kind_t'(kind), range_mm, last_of_scan);
      end
      if (out_valid && out_ready) begin
        if (steer_expect_q.size() == 0) begin
          report_mismatch("steering transaction with none pending, case_code",
                          int'(case_code), -1);
        end else begin
          want = steer_expect_q.pop_front();
          if (case_code !== want.code) begin
            report_mismatch("case_code", int'(case_code), int'(want.code));
          end
          if (linear_mm_s !== want.lin) begin
            report_mismatch("linear_mm_s", int'(linear_mm_s), int'(want.lin));
          end
          if (angular_mrad_s !== want.ang) begin
            report_mismatch("angular_mrad_s", int'(angular_mrad_s), int'(want.ang));
          end
        end
      end
    end
  end

  // Receiver: random stalls per transaction, plus a long hold-off on request
  initial begin : steer_sink
    int stall;
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      stall = $urandom_range(0, rx_gap_max);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic offer_reading(lsos_pkg::kind_t k, logic [15:0] r, logic is_last);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    range_mm = r;
    last_of_scan = is_last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (steer_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(lsos_pkg::reg_index_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_sectors(logic [15:0] thr, logic [15:0] front, logic [15:0] left,
                                 logic [15:0] right, logic [15:0] width);
    wait_drained();
    write_reg(lsos_pkg::REG_THRESHOLD, thr);
    write_reg(lsos_pkg::REG_FRONT_START, front);
    write_reg(lsos_pkg::REG_LEFT_START, left);
    write_reg(lsos_pkg::REG_RIGHT_START, right);
    write_reg(lsos_pkg::REG_SECTOR_W, width);
  endtask

  // Narrow layout: right at 0, front at 1, left at 2, one sample each
  task automatic scan_three_sectors(logic [15:0] right_r, logic [15:0] front_r,
                                    logic [15:0] left_r);
    offer_reading(lsos_pkg::KIND_SAMPLE, right_r, 1'b0);
    offer_reading(lsos_pkg::KIND_SAMPLE, front_r, 1'b0);
    offer_reading(lsos_pkg::KIND_SAMPLE, left_r, 1'b1);
  endtask

  function automatic logic [15:0] pick_range(int below_pct);
    int roll;
    int thr;
    thr = int'(shadow_thr);
    roll = $urandom_range(0, 99);
    if (roll < below_pct && thr > 0) return 16'($urandom_range(0, thr - 1));
    if (roll < below_pct + 4) return 16'(thr);
    if (roll < below_pct + 10) return 16'($urandom);
    if (thr < 65535) return 16'($urandom_range(thr + 1, 65535));
    return 16'hFFFF;
  endfunction

  task automatic test_default_layout();
    tx_gap_max = 3;
    rx_gap_max = 3;
    // position 0 lies in no default sector
    offer_reading(lsos_pkg::KIND_SAMPLE, 16'd100, 1'b1);
    for (int i = 0; i < 510; i++) begin
      if (i == 360) offer_reading(lsos_pkg::KIND_SAMPLE, 16'd400, 1'b0);
      else if (i == 215) offer_reading(lsos_pkg::KIND_SAMPLE, 16'd899, 1'b0);
      else offer_reading(lsos_pkg::KIND_SAMPLE, 16'($urandom_range(901, 65535)), i == 509);
    end
  endtask

  task automatic test_case_table();
    program_sectors(16'd1000, 16'd1, 16'd2, 16'd0, 16'd1);
    tx_gap_max = 0;
    rx_gap_max = 0;
    for (int c = 0; c < 8; c++) begin
      scan_three_sectors(c[0] ? 16'd500 : 16'd2000, c[2] ? 16'd500 : 16'd2000,
                         c[1] ? 16'd500 : 16'd2000);
    end
  endtask

  task automatic test_threshold_edges();
    tx_gap_max = 11;
    rx_gap_max = 11;
    scan_three_sectors(16'd2000, 16'd2000, 16'd2000);
    // exact hit: unknown, speeds held
    scan_three_sectors(16'd1000, 16'd2000, 16'd2000);
    scan_three_sectors(16'd500, 16'd1000, 16'd2000);
    scan_three_sectors(16'd0, 16'hFFFF, 16'hFFFF);
    program_sectors(16'd0, 16'd1, 16'd2, 16'd0, 16'd1);
    scan_three_sectors(16'd0, 16'd1, 16'd1);
    scan_three_sectors(16'd1, 16'hFFFF, 16'd5);
    program_sectors(16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd1);
    scan_three_sectors(16'hFFFF, 16'hFFFF, 16'hFFFF);
    // untouched sectors sit at 30 m
    program_sectors(16'd30000, 16'd1, 16'd2, 16'd0, 16'd1);
    offer_reading(lsos_pkg::KIND_SAMPLE, 16'd40000, 1'b1);
    program_sectors(16'd29999, 16'd1, 16'd2, 16'd0, 16'd1);
    offer_reading(lsos_pkg::KIND_SAMPLE, 16'd30000, 1'b1);
  endtask

  task automatic test_sector_shapes();
    tx_gap_max = 2;
    rx_gap_max = 5;
    program_sectors(16'd1000, 16'd1, 16'd2, 16'd0, 16'd0);
    scan_three_sectors(16'd0, 16'd0, 16'd0);
    program_sectors(16'd1000, 16'd0, 16'd100, 16'hFFF, 16'd127);
    scan_three_sectors(16'd2000, 16'd2000, 16'd5);
    for (int i = 0; i < 102; i++) begin
      offer_reading(lsos_pkg::KIND_SAMPLE, (i == 101) ? 16'd7 : 16'd5000, i == 101);
    end
    // width field is 7 bits; upper data bits must be dropped
    program_sectors(16'd1000, 16'hF001, 16'hA002, 16'h5000, 16'hFF81);
    scan_three_sectors(16'd500, 16'd500, 16'd500);
  endtask

  task automatic test_speed_commands();
    program_sectors(16'd1000, 16'd1, 16'd2, 16'd0, 16'd1);
    tx_gap_max = 5;
    rx_gap_max = 0;
    repeat (20) begin
      offer_reading(lsos_pkg::KIND_SPEED_UP, 16'($urandom), 1'($urandom_range(0, 1)));
    end
    scan_three_sectors(16'd2000, 16'd2000, 16'd2000);
    scan_three_sectors(16'd500, 16'd2000, 16'd500);
    offer_reading(lsos_pkg::KIND_UNUSED, 16'd0, 1'b1);
    repeat (40) begin
      offer_reading(lsos_pkg::KIND_SLOW_DOWN, 16'($urandom), 1'($urandom_range(0, 1)));
    end
    scan_three_sectors(16'd2000, 16'd1000, 16'd2000);
    scan_three_sectors(16'd2000, 16'd2000, 16'd2000);
    scan_three_sectors(16'd500, 16'd2000, 16'd500);
    repeat (17) offer_reading(lsos_pkg::KIND_SPEED_UP, 16'($urandom), 1'b1);
    scan_three_sectors(16'd2000, 16'd500, 16'd2000);
  endtask

  task automatic test_long_scan();
    program_sectors(16'd1000, 16'd719, 16'hFFF, 16'd2, 16'd2);
    tx_gap_max = 1;
    rx_gap_max = 2;
    // no end mark: position wraps and the minimums carry over
    for (int i = 0; i < ScanLen; i++) begin
      if (i == 2) offer_reading(lsos_pkg::KIND_SAMPLE, 16'd10, 1'b0);
      else if (i == 719) offer_reading(lsos_pkg::KIND_SAMPLE, 16'd20, 1'b0);
      else offer_reading(lsos_pkg::KIND_SAMPLE, 16'd5000, 1'b0);
    end
    scan_three_sectors(16'd5000, 16'd5000, 16'd5000);
  endtask

  task automatic test_backpressure();
    program_sectors(16'd1000, 16'd1, 16'd2, 16'd0, 16'd1);
    tx_gap_max = 0;
    rx_gap_max = 0;
    hold_off_cycles = 150;
    repeat (40) offer_reading(lsos_pkg::KIND_SAMPLE, 16'($urandom_range(0, 2000)), 1'b1);
  endtask

  task automatic test_random_traffic();
    int len, below_pct, roll;
    logic [15:0] thr, front, left, right, width;
    while (random_items < RandomItems) begin
      thr = ($urandom_range(0, 9) < 3) ? 16'($urandom) : 16'($urandom_range(200, 3000));
      front = 16'(($urandom & 16'hF000) | (($urandom_range(0, 9) == 0) ?
                                           $urandom_range(0, 4095) : $urandom_range(0, 20)));
      left = 16'(($urandom & 16'hF000) | (($urandom_range(0, 9) == 0) ?
                                          $urandom_range(0, 4095) : $urandom_range(0, 20)));
      right = 16'(($urandom & 16'hF000) | $urandom_range(0, 20));
      roll = $urandom_range(0, 9);
      width = 16'(($urandom & 16'hFF80) | ((roll == 0) ? 0 :
                                            (roll == 1) ? $urandom_range(0, 127)
                                                        : $urandom_range(1, 12)));
      program_sectors(thr, front, left, right, width);
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      repeat ($urandom_range(6, 14)) begin
        len = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0: below_pct = 0;
          1: below_pct = 5;
          2: below_pct = 20;
          default: below_pct = 60;
        endcase
        for (int i = 0; i < len; i++) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            offer_reading((roll < 4) ? lsos_pkg::KIND_SPEED_UP : lsos_pkg::KIND_SLOW_DOWN,
                          16'($urandom), 1'($urandom_range(0, 1)));
            random_items++;
          end else if (roll < 10) begin
            offer_reading(lsos_pkg::KIND_UNUSED, 16'($urandom), 1'($urandom_range(0, 1)));
          end
          offer_reading(lsos_pkg::KIND_SAMPLE, pick_range(below_pct), i == len - 1);
          random_items++;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = lsos_pkg::KIND_SAMPLE;
    range_mm = '0;
    last_of_scan = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_layout();
    test_case_table();
    test_threshold_edges();
    test_sector_shapes();
    test_speed_commands();
    test_long_scan();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lsos_pkg.sv
hw/rtl/lidar_sector_obstacle_steer_unit.sv
test/lidar_sector_obstacle_steer_unit_tb.sv
